/* rtl/cbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int OP_W    = 3;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int KIND_W  = 3;
    localparam int SLOT_W  = 3;
    localparam int VAL_W   = 11;
    localparam int LAST_W  = 1;
    localparam int SIZE_W  = 8;
    localparam int CNT_W   = 16;
    localparam int BASE_W  = 10;
    localparam int IDX_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam int TICK_STEP_DEF = 114;

    // opcodes
    localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
    localparam logic [OP_W-1:0] OP_CART_WR = 3'd1;
    localparam logic [OP_W-1:0] OP_EXP_WR  = 3'd2;
    localparam logic [OP_W-1:0] OP_EXP_RD  = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PRG  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CHR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MIRR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IRQ  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] PRG_SIZE_RST = 8'd16;
    localparam logic [SIZE_W-1:0] CHR_SIZE_RST = 8'd32;
    localparam logic [SIZE_W-1:0] PRG_SIZE_LARGE = 8'd16;
    localparam logic [SIZE_W-1:0] CHR_SIZE_MODE_MAX = 8'd32;

    // register addresses
    localparam logic [ADDR_W-1:0] ADDR_OUTER0   = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_OUTER1   = 16'hB000;
    localparam logic [ADDR_W-1:0] ADDR_OUTER2   = 16'hB0FF;
    localparam logic [ADDR_W-1:0] ADDR_OUTER3   = 16'hB1FF;
    localparam logic [ADDR_W-1:0] ADDR_MIRROR   = 16'h8100;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_LO   = 16'h8200;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_HI   = 16'h8201;
    localparam logic [ADDR_W-1:0] ADDR_PRG_LO   = 16'h8300;
    localparam logic [ADDR_W-1:0] ADDR_PRG_HI   = 16'h8302;
    localparam logic [ADDR_W-1:0] ADDR_CHR_LO   = 16'h8310;
    localparam logic [ADDR_W-1:0] ADDR_CHR_HI   = 16'h8317;
    localparam logic [ADDR_W-1:0] ADDR_PRG_PAIR = 16'h8318;
    localparam logic [ADDR_W-1:0] ADDR_EXP_LO   = 16'h5101;
    localparam logic [ADDR_W-1:0] ADDR_EXP_HI   = 16'h5103;
    localparam logic [ADDR_W-1:0] EXP_MASK      = 16'h5100;

    localparam logic [DATA_W-1:0] MODE_LARGE  = 8'h30;
    localparam logic [DATA_W-1:0] OUTER_MASK  = 8'h30;
    localparam logic [DATA_W-1:0] HI_FILL     = 8'h0F;

    localparam logic [VAL_W-1:0] INIT_PAGE2_LARGE = 11'd30;
    localparam logic [VAL_W-1:0] INIT_PAGE3_LARGE = 11'd31;

    typedef enum logic [3:0] {
        PL_NONE,
        PL_INIT,
        PL_OUTER,
        PL_MIRROR,
        PL_PRG1,
        PL_CHR1,
        PL_CHR2,
        PL_PRG2,
        PL_READ,
        PL_IRQ
    } cbm_plan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GEN,
        ST_MOD,
        ST_OUT
    } cbm_state_t;

    typedef struct packed {
        logic take;
        logic decode;
        logic idx_clr;
        logic idx_inc;
        logic mod_start;
        logic load_raw;
        logic load_mod;
    } cbm_cmd_t;

    typedef struct packed {
        logic need_mod;
        logic last;
        logic mod_done;
    } cbm_status_t;

endpackage
`default_nettype wire

/* rtl/cbm_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_mod
// Restoring remainder unit, one quotient bit per cycle; zero divisor gives 0.
// ----------------------------------------------------------------------------
module cbm_mod (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [cbm_pkg::VAL_W-1:0] dividend,
    input  wire logic [cbm_pkg::VAL_W-1:0] divisor,
    output logic                          done,
    output logic [cbm_pkg::VAL_W-1:0]     result
);
    import cbm_pkg::*;

    localparam int STEP_W = $clog2(VAL_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VAL_W - 1);

    logic [VAL_W-1:0]   rem_reg;
    logic [2*VAL_W-1:0] den_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               zero_reg;
    logic               fits;
    logic [VAL_W-1:0]   rem_next;

    assign fits     = {{VAL_W{1'b0}}, rem_reg} >= den_reg;
    assign rem_next = fits ? (rem_reg - den_reg[VAL_W-1:0]) : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && step_reg == '0) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            den_reg  <= {divisor, {(VAL_W-1){1'b0}}, 1'b0} >> 1;
            step_reg <= LAST_STEP;
            zero_reg <= divisor == '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            den_reg  <= den_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
    end

    assign done   = done_reg;
    assign result = zero_reg ? '0 : rem_reg;

endmodule
`default_nettype wire

/* rtl/cbm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_datapath
// Mapper state, configuration, item decode, result generation and output
// register.
// ----------------------------------------------------------------------------
module cbm_datapath #(
    parameter int TICK_STEP = cbm_pkg::TICK_STEP_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cbm_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic [cbm_pkg::OP_W-1:0]      s_opcode,
    input  wire logic [cbm_pkg::ADDR_W-1:0]    s_address,
    input  wire logic [cbm_pkg::DATA_W-1:0]    s_data,
    input  wire cbm_pkg::cbm_cmd_t             cmd,
    output cbm_pkg::cbm_status_t               status,
    output logic [cbm_pkg::KIND_W-1:0]         m_kind,
    output logic [cbm_pkg::SLOT_W-1:0]         m_slot,
    output logic [cbm_pkg::VAL_W-1:0]          m_value,
    output logic [cbm_pkg::LAST_W-1:0]         m_last
);
    import cbm_pkg::*;

    localparam logic [CNT_W-1:0] STEP = CNT_W'(TICK_STEP);

    // configuration
    logic [SIZE_W-1:0] prg_size_reg;
    logic [SIZE_W-1:0] chr_size_reg;

    // latched item
    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;

    // mapper state
    logic [DATA_W-1:0] outer_bank_reg, outer_bank_next;
    logic [DATA_W-1:0] mode_reg, mode_next;
    logic [DATA_W-1:0] exp_latch_reg, exp_latch_next;
    logic [BASE_W-1:0] chr_base_reg, chr_base_next;
    logic [CNT_W-1:0]  irq_count_reg, irq_count_next;
    logic              irq_armed_reg, irq_armed_next;
    cbm_plan_t         plan_reg, plan_next;
    logic [IDX_W-1:0]  idx_reg;

    // result generation
    logic [KIND_W-1:0] gen_kind;
    logic [SLOT_W-1:0] gen_slot;
    logic [VAL_W-1:0]  gen_value;
    logic              gen_need_mod;
    logic              gen_chr_sel;
    logic              gen_last;

    logic [VAL_W-1:0]  prg_pages;
    logic [VAL_W-1:0]  chr_pages;
    logic [VAL_W-1:0]  init_page2;
    logic [VAL_W-1:0]  init_page3;
    logic [DATA_W-1:0] outer_hi;
    logic [DATA_W-1:0] pair_hi;
    logic [BASE_W-1:0] chr_page;
    logic [SLOT_W-1:0] pair_slot;
    logic [IDX_W-1:0]  chr_idx;

    logic              mod_done;
    logic [VAL_W-1:0]  mod_result;

    logic [KIND_W-1:0] kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_size_reg <= PRG_SIZE_RST;
            chr_size_reg <= CHR_SIZE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PRG_SIZE: prg_size_reg <= cfg_data;
                CFG_CHR_SIZE: chr_size_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg   <= s_opcode;
            addr_reg <= s_address;
            data_reg <= s_data;
        end
    end

    // state update and result plan, from the state before the item
    always_comb begin
        plan_next       = PL_NONE;
        outer_bank_next = outer_bank_reg;
        mode_next       = mode_reg;
        exp_latch_next  = exp_latch_reg;
        chr_base_next   = chr_base_reg;
        irq_count_next  = irq_count_reg;
        irq_armed_next  = irq_armed_reg;
        unique case (op_reg)
            OP_INIT: begin
                plan_next       = PL_INIT;
                outer_bank_next = '0;
                mode_next       = (prg_size_reg >= PRG_SIZE_LARGE) ? MODE_LARGE : '0;
                exp_latch_next  = '0;
                chr_base_next   = '0;
                irq_count_next  = '0;
                irq_armed_next  = 1'b0;
            end
            OP_CART_WR: begin
                priority if (addr_reg == ADDR_OUTER0 || addr_reg == ADDR_OUTER1 ||
                             addr_reg == ADDR_OUTER2 || addr_reg == ADDR_OUTER3) begin
                    plan_next       = PL_OUTER;
                    outer_bank_next = data_reg;
                    chr_base_next   = {data_reg[5:4], 8'h00};
                end else if (addr_reg == ADDR_MIRROR) begin
                    plan_next = PL_MIRROR;
                    if (chr_size_reg <= CHR_SIZE_MODE_MAX) begin
                        mode_next = data_reg;
                    end
                end else if (addr_reg == ADDR_IRQ_LO) begin
                    irq_count_next = {irq_count_reg[15:8], data_reg};
                end else if (addr_reg == ADDR_IRQ_HI) begin
                    irq_count_next = {data_reg, irq_count_reg[7:0]};
                    irq_armed_next = data_reg != '0;
                end else if (addr_reg >= ADDR_PRG_LO && addr_reg <= ADDR_PRG_HI) begin
                    plan_next = PL_PRG1;
                end else if (addr_reg >= ADDR_CHR_LO && addr_reg <= ADDR_CHR_HI) begin
                    if (chr_size_reg != '0) begin
                        unique case (mode_reg[5:4])
                            2'b11:        plan_next = PL_CHR1;
                            2'b01, 2'b10: plan_next = PL_CHR2;
                            default:      plan_next = PL_NONE;
                        endcase
                    end
                end else if (addr_reg == ADDR_PRG_PAIR) begin
                    plan_next = PL_PRG2;
                end
            end
            OP_EXP_WR: begin
                if (addr_reg >= ADDR_EXP_LO && addr_reg <= ADDR_EXP_HI) begin
                    exp_latch_next = data_reg;
                end
            end
            OP_EXP_RD: begin
                plan_next = PL_READ;
            end
            OP_TICK: begin
                if (irq_armed_reg) begin
                    if (irq_count_reg <= STEP) begin
                        plan_next      = PL_IRQ;
                        irq_armed_next = 1'b0;
                    end else begin
                        irq_count_next = irq_count_reg - STEP;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_reg       <= PL_NONE;
            outer_bank_reg <= '0;
            mode_reg       <= '0;
            exp_latch_reg  <= '0;
            chr_base_reg   <= '0;
            irq_count_reg  <= '0;
            irq_armed_reg  <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (cmd.decode) begin
                plan_reg       <= plan_next;
                outer_bank_reg <= outer_bank_next;
                mode_reg       <= mode_next;
                exp_latch_reg  <= exp_latch_next;
                chr_base_reg   <= chr_base_next;
                irq_count_reg  <= irq_count_next;
                irq_armed_reg  <= irq_armed_next;
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign prg_pages  = {2'b00, prg_size_reg, 1'b0};
    assign chr_pages  = {chr_size_reg, 3'b000};
    assign init_page2 = (prg_size_reg >= PRG_SIZE_LARGE) ? INIT_PAGE2_LARGE :
                        (prg_size_reg != '0) ? (prg_pages - VAL_W'(2)) : '0;
    assign init_page3 = (prg_size_reg >= PRG_SIZE_LARGE) ? INIT_PAGE3_LARGE :
                        (prg_size_reg != '0) ? (prg_pages - VAL_W'(1)) : '0;
    assign outer_hi   = (data_reg & OUTER_MASK) | HI_FILL;
    assign pair_hi    = (outer_bank_reg & OUTER_MASK) | data_reg;
    assign chr_page   = chr_base_reg ^ {2'b00, data_reg};
    assign pair_slot  = addr_reg[2] ? {1'b1, addr_reg[0], 1'b0} : {addr_reg[1:0], 1'b0};
    assign chr_idx    = idx_reg - IDX_W'(4);

    always_comb begin
        gen_kind     = KIND_NONE;
        gen_slot     = '0;
        gen_value    = '0;
        gen_need_mod = 1'b0;
        gen_chr_sel  = 1'b0;
        gen_last     = 1'b1;
        unique case (plan_reg)
            PL_INIT: begin
                if (idx_reg < IDX_W'(4)) begin
                    gen_kind = KIND_PRG;
                    gen_slot = {1'b0, idx_reg[1:0]};
                    unique case (idx_reg[1:0])
                        2'd0: gen_value = '0;
                        2'd1: gen_value = VAL_W'(1);
                        2'd2: gen_value = init_page2;
                        2'd3: gen_value = init_page3;
                    endcase
                end else begin
                    gen_kind  = KIND_CHR;
                    gen_slot  = chr_idx[SLOT_W-1:0];
                    gen_value = VAL_W'(chr_idx);
                end
                gen_last = (chr_size_reg != '0) ? (idx_reg == IDX_W'(11))
                                                : (idx_reg == IDX_W'(3));
            end
            PL_OUTER: begin
                gen_kind     = KIND_PRG;
                gen_slot     = {1'b0, idx_reg[1:0]};
                gen_value    = {2'b00, (idx_reg[1] ? outer_hi : data_reg), idx_reg[0]};
                gen_need_mod = 1'b1;
                gen_last     = idx_reg[1:0] == 2'd3;
            end
            PL_MIRROR: begin
                gen_kind  = KIND_MIRR;
                gen_value = {9'd0, data_reg[1:0] ^ 2'b01};
            end
            PL_PRG1: begin
                gen_kind     = KIND_PRG;
                gen_slot     = {1'b0, addr_reg[1:0]};
                gen_value    = {3'b000, data_reg};
                gen_need_mod = 1'b1;
            end
            PL_CHR1: begin
                gen_kind     = KIND_CHR;
                gen_slot     = addr_reg[2:0];
                gen_value    = {1'b0, chr_page};
                gen_need_mod = 1'b1;
                gen_chr_sel  = 1'b1;
            end
            PL_CHR2: begin
                gen_kind     = KIND_CHR;
                gen_slot     = pair_slot | {2'b00, idx_reg[0]};
                gen_value    = {chr_page, idx_reg[0]};
                gen_need_mod = 1'b1;
                gen_chr_sel  = 1'b1;
                gen_last     = idx_reg[0];
            end
            PL_PRG2: begin
                gen_kind     = KIND_PRG;
                gen_slot     = {2'b00, idx_reg[0]};
                gen_value    = {2'b00, pair_hi, idx_reg[0]};
                gen_need_mod = 1'b1;
                gen_last     = idx_reg[0];
            end
            PL_READ: begin
                gen_kind  = KIND_READ;
                gen_value = ((addr_reg & EXP_MASK) == EXP_MASK) ? {3'b000, exp_latch_reg}
                                                                : {3'b000, addr_reg[15:8]};
            end
            PL_IRQ: begin
                gen_kind = KIND_IRQ;
            end
            default: ;
        endcase
    end

    cbm_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (gen_value),
        .divisor  (gen_chr_sel ? chr_pages : prg_pages),
        .done     (mod_done),
        .result   (mod_result)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_raw || cmd.load_mod) begin
            kind_reg  <= gen_kind;
            slot_reg  <= gen_slot;
            value_reg <= cmd.load_mod ? mod_result : gen_value;
            last_reg  <= gen_last;
        end
    end

    assign status.need_mod = gen_need_mod;
    assign status.last     = gen_last;
    assign status.mod_done = mod_done;

    assign m_kind  = kind_reg;
    assign m_slot  = slot_reg;
    assign m_value = value_reg;
    assign m_last  = last_reg;

endmodule
`default_nettype wire

/* rtl/cbm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_ctrl
// Sequencer: takes an item, decodes it, then walks its results one by one.
// ----------------------------------------------------------------------------
module cbm_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire cbm_pkg::cbm_status_t status,
    output cbm_pkg::cbm_cmd_t         cmd
);
    import cbm_pkg::*;

    cbm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode  = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = ST_GEN;
            end
            ST_GEN: begin
                if (status.need_mod) begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end else begin
                    cmd.load_raw = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_MOD: begin
                if (status.mod_done) begin
                    cmd.load_mod = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_GEN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/cartridge_bank_mapper_with_scanline_irq_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_scanline_irq_top
// Bank mapper with scanline IRQ counter: init, cartridge and expansion
// accesses and scanline ticks in, slot, mirroring, read, irq or empty results out.
// ----------------------------------------------------------------------------
// One item is handled at a time. The item is latched when it is taken and
// decoded in the decode state; then every result is built in turn. A result
// that needs a page taken modulo the page count goes through an 11-step
// remainder unit before it is loaded into the output register; any other
// result is loaded there straight from the generator. Each result is then
// held until the sink takes it. Configuration writes land at once and
// are expected only while no item is in flight.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_scanline_irq_top #(
    parameter int TICK_STEP = cbm_pkg::TICK_STEP_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cbm_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [cbm_pkg::OP_W-1:0]      s_opcode,
    input  wire logic [cbm_pkg::ADDR_W-1:0]    s_address,
    input  wire logic [cbm_pkg::DATA_W-1:0]    s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [cbm_pkg::KIND_W-1:0]         m_kind,
    output logic [cbm_pkg::SLOT_W-1:0]         m_slot,
    output logic [cbm_pkg::VAL_W-1:0]          m_value,
    output logic [cbm_pkg::LAST_W-1:0]         m_last
);
    import cbm_pkg::*;

    cbm_cmd_t    cmd;
    cbm_status_t status;

    cbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cbm_datapath #(
        .TICK_STEP (TICK_STEP)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_opcode  (s_opcode),
        .s_address (s_address),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_kind    (m_kind),
        .m_slot    (m_slot),
        .m_value   (m_value),
        .m_last    (m_last)
    );

endmodule
`default_nettype wire

/* verif/cartridge_bank_mapper_with_scanline_irq_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_scanline_irq_top_tb
// Self-checking bench for the bank mapper: a directed pass over the register
// map, then randomized bus traffic under several ROM size settings. A local
// mapper model predicts every slot, mirroring, read and irq result, and the
// monitor checks each output transfer against it in order.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_scanline_irq_top_tb;
    import cbm_pkg::*;

    localparam int TICK = TICK_STEP_DEF;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 64;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 48;
    localparam logic [DATA_W-1:0] MODE_2K_A = 8'h10;
    localparam logic [DATA_W-1:0] MODE_2K_B = 8'h20;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } cpu_op_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  value;
        logic [LAST_W-1:0] last;
    } bank_update_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PRG_SIZE;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_opcode = OP_INIT;
    logic [ADDR_W-1:0] s_address = '0;
    logic [DATA_W-1:0] s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [KIND_W-1:0] m_kind;
    logic [SLOT_W-1:0] m_slot;
    logic [VAL_W-1:0] m_value;
    logic [LAST_W-1:0] m_last;

    // mapper model state
    logic [SIZE_W-1:0] prg_size = PRG_SIZE_RST;
    logic [SIZE_W-1:0] chr_size = CHR_SIZE_RST;
    logic [DATA_W-1:0] outer_sel = '0;
    logic [DATA_W-1:0] mode_sel = '0;
    logic [DATA_W-1:0] exp_latch = '0;
    logic [BASE_W-1:0] chr_base = '0;
    logic [CNT_W-1:0] irq_cnt = '0;
    logic irq_on = 1'b0;

    bank_update_t item_res [12];
    int item_n;
    bank_update_t bank_update_q [$];
    cpu_op_t cpu_ops_q [$];
    bank_update_t want;

    logic s_taken = 1'b0;
    logic idle_on = 1'b1;
    int src_gap = 0;
    int sink_gap = 0;
    int hold_req = 0;
    int hold_done = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    cartridge_bank_mapper_with_scanline_irq_top #(
        .TICK_STEP(TICK)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_address(s_address),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_slot(m_slot),
        .m_value(m_value),
        .m_last(m_last)
    );

    always #10 aclk = ~aclk;

    // ---------------- mapper model ----------------

    task automatic add_update(input logic [KIND_W-1:0] kind, input int slot, input int value);
        bank_update_t r;
        r.kind = kind;
        r.slot = slot[SLOT_W-1:0];
        r.value = value[VAL_W-1:0];
        r.last = 1'b0;
        item_res[item_n] = r;
        item_n++;
    endtask

    task automatic set_prg(input int slot, input int page);
        int n;
        n = int'(prg_size) * 2;
        add_update(KIND_PRG, slot, n == 0 ? 0 : page % n);
    endtask

    task automatic set_chr(input int slot, input int page);
        int n;
        n = int'(chr_size) * 8;
        add_update(KIND_CHR, slot, n == 0 ? 0 : page % n);
    endtask

    task automatic power_on();
        int n;
        n = int'(prg_size) * 2;
        outer_sel = '0;
        mode_sel = '0;
        exp_latch = '0;
        chr_base = '0;
        irq_cnt = '0;
        irq_on = 1'b0;
        add_update(KIND_PRG, 0, 0);
        add_update(KIND_PRG, 1, 1);
        if (n >= 32) begin
            add_update(KIND_PRG, 2, int'(INIT_PAGE2_LARGE));
            add_update(KIND_PRG, 3, int'(INIT_PAGE3_LARGE));
            mode_sel = MODE_LARGE;
        end else begin
            add_update(KIND_PRG, 2, n >= 2 ? n - 2 : 0);
            add_update(KIND_PRG, 3, n >= 1 ? n - 1 : 0);
        end
        if (chr_size != 0) begin
            for (int i = 0; i < 8; i++) begin
                add_update(KIND_CHR, i, i);
            end
        end
    endtask

    task automatic chr_bank_write(input int sel, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] mode;
        int page;
        int pair;
        mode = mode_sel & MODE_LARGE;
        page = int'((chr_base ^ {2'b00, data}) & 10'h3FF);
        if (chr_size != 0) begin
            if (mode == MODE_LARGE) begin
                set_chr(sel, page);
            end else if (mode == MODE_2K_A || mode == MODE_2K_B) begin
                pair = (sel < 4) ? sel : (4 + (sel & 1) * 2) / 2;
                pair = pair * 2;
                set_chr(pair, page * 2);
                set_chr(pair + 1, page * 2 + 1);
            end
        end
    endtask

    task automatic cart_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        int d;
        int hi;
        d = int'(data);
        if (addr == ADDR_OUTER0 || addr == ADDR_OUTER1 || addr == ADDR_OUTER2
                || addr == ADDR_OUTER3) begin
            outer_sel = data;
            chr_base = {data[5:4], 8'h00};
            hi = int'((data & OUTER_MASK) | HI_FILL);
            set_prg(0, d * 2);
            set_prg(1, d * 2 + 1);
            set_prg(2, hi * 2);
            set_prg(3, hi * 2 + 1);
        end else if (addr == ADDR_MIRROR) begin
            if (chr_size <= CHR_SIZE_MODE_MAX) begin
                mode_sel = data;
            end
            add_update(KIND_MIRR, 0, int'({data[1], ~data[0]}));
        end else if (addr == ADDR_IRQ_LO) begin
            irq_cnt[7:0] = data;
        end else if (addr == ADDR_IRQ_HI) begin
            irq_cnt[15:8] = data;
            irq_on = (data != 0);
        end else if (addr >= ADDR_PRG_LO && addr <= ADDR_PRG_HI) begin
            set_prg(int'(addr - ADDR_PRG_LO), d);
        end else if (addr >= ADDR_CHR_LO && addr <= ADDR_CHR_HI) begin
            chr_bank_write(int'(addr[2:0]), data);
        end else if (addr == ADDR_PRG_PAIR) begin
            hi = int'(outer_sel & OUTER_MASK) | d;
            set_prg(0, hi * 2);
            set_prg(1, hi * 2 + 1);
        end
    endtask

    task automatic apply_cpu_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        bank_update_t r;
        item_n = 0;
        case (op)
            OP_INIT: begin
                power_on();
            end
            OP_CART_WR: begin
                cart_write(addr, data);
            end
            OP_EXP_WR: begin
                if (addr >= ADDR_EXP_LO && addr <= ADDR_EXP_HI) begin
                    exp_latch = data;
                end
            end
            OP_EXP_RD: begin
                if ((addr & EXP_MASK) == EXP_MASK) begin
                    add_update(KIND_READ, 0, int'(exp_latch));
                end else begin
                    add_update(KIND_READ, 0, int'(addr[15:8]));
                end
            end
            OP_TICK: begin
                if (irq_on) begin
                    if (int'(irq_cnt) <= TICK) begin
                        add_update(KIND_IRQ, 0, 0);
                        irq_on = 1'b0;
                    end else begin
                        irq_cnt = irq_cnt - CNT_W'(TICK);
                    end
                end
            end
            default: begin
            end
        endcase
        if (item_n == 0) begin
            add_update(KIND_NONE, 0, 0);
        end
        for (int i = 0; i < item_n; i++) begin
            r = item_res[i];
            r.last = (i == item_n - 1);
            bank_update_q.push_back(r);
        end
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic logic [ADDR_W-1:0] cart_addr();
        case ($urandom_range(0, 12))
            0: return ADDR_OUTER0;
            1: return ADDR_OUTER1;
            2: return ADDR_OUTER2;
            3: return ADDR_OUTER3;
            4: return ADDR_MIRROR;
            5: return ADDR_IRQ_LO;
            6: return ADDR_IRQ_HI;
            7: return ADDR_PRG_LO + ADDR_W'($urandom_range(0, 2));
            8, 9, 10: return ADDR_CHR_LO + ADDR_W'($urandom_range(0, 7));
            11: return ADDR_PRG_PAIR;
            default: return ADDR_W'($urandom_range(16'h82FF, 16'h8320));
        endcase
    endfunction

    function automatic cpu_op_t rand_cpu_op();
        cpu_op_t it;
        int r;
        it.op = OP_CART_WR;
        it.addr = ADDR_W'($urandom_range(0, 16'hFFFF));
        it.data = DATA_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 4) begin
            it.op = OP_INIT;
        end else if (r < 48) begin
            it.addr = cart_addr();
        end else if (r < 55) begin
            it.addr = ADDR_IRQ_HI;
            it.data = DATA_W'($urandom_range(0, 2));
        end else if (r < 61) begin
            it.op = OP_EXP_WR;
            it.addr = ADDR_EXP_LO - ADDR_W'(1) + ADDR_W'($urandom_range(0, 4));
        end else if (r < 69) begin
            it.op = OP_EXP_RD;
            if ($urandom_range(0, 1) == 1) begin
                it.addr = it.addr | EXP_MASK;
            end
        end else if (r < 92) begin
            it.op = OP_TICK;
        end else begin
            it.op = OP_W'($urandom_range(0, 7));
        end
        return it;
    endfunction

    task automatic push_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
        cpu_op_t it;
        it.op = op;
        it.addr = addr;
        it.data = data;
        cpu_ops_q.push_back(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_PRG_SIZE) begin
            prg_size = val;
        end else begin
            chr_size = val;
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (cpu_ops_q.size() != 0 || s_valid || bank_update_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ---------------- sequence ----------------

    initial begin
        logic [SIZE_W-1:0] prg_set [PHASES];
        logic [SIZE_W-1:0] chr_set [PHASES];
        prg_set = '{8'd1, 8'd255, 8'd15, 8'd16, 8'd0, 8'd64, 8'd2, 8'd1};
        chr_set = '{8'd0, 8'd255, 8'd32, 8'd33, 8'd8, 8'd1, 8'd200, 8'd0};
        prg_set[7] = SIZE_W'($urandom_range(1, 255));
        chr_set[7] = SIZE_W'($urandom_range(0, 255));
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed pass at reset sizes
        push_op(OP_INIT, 16'hFFFF, 8'hFF);
        push_op(OP_CART_WR, ADDR_OUTER0, 8'hFF);
        push_op(OP_CART_WR, ADDR_OUTER1, 8'h00);
        push_op(OP_CART_WR, ADDR_OUTER2, 8'h35);
        push_op(OP_CART_WR, ADDR_CHR_HI, 8'hA5);
        push_op(OP_CART_WR, ADDR_OUTER3, 8'h20);
        push_op(OP_CART_WR, ADDR_MIRROR, 8'h03);
        push_op(OP_CART_WR, ADDR_CHR_LO, 8'hAA);
        push_op(OP_CART_WR, ADDR_MIRROR, 8'h10);
        push_op(OP_CART_WR, ADDR_CHR_LO + 16'd5, 8'hFF);
        push_op(OP_CART_WR, ADDR_MIRROR, 8'h30);
        push_op(OP_CART_WR, ADDR_CHR_HI, 8'h00);
        push_op(OP_CART_WR, ADDR_PRG_LO, 8'h80);
        push_op(OP_CART_WR, ADDR_PRG_HI, 8'hFF);
        push_op(OP_CART_WR, ADDR_PRG_PAIR, 8'h0F);
        push_op(OP_CART_WR, ADDR_IRQ_LO, 8'h10);
        push_op(OP_CART_WR, ADDR_IRQ_HI, 8'h01);
        repeat (4) push_op(OP_TICK, 16'h0000, 8'h00);
        push_op(OP_EXP_WR, ADDR_EXP_LO, 8'h5A);
        push_op(OP_EXP_RD, EXP_MASK, 8'h00);
        push_op(OP_EXP_RD, 16'h0000, 8'hFF);
        push_op(OP_CART_WR, 16'h1234, 8'h77);
        push_op(3'd7, 16'hFFFF, 8'hFF);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_PRG_SIZE, prg_set[ph]);
            write_reg(CFG_CHR_SIZE, chr_set[ph]);
            idle_on = (ph != 2);
            push_op(OP_INIT, 16'h0000, 8'h00);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                cpu_ops_q.push_back(rand_cpu_op());
            end
            if (ph == 4) begin
                hold_req = hold_req + 1;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // ---------------- driver ----------------

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (cpu_ops_q.size() > 0) begin
                s_opcode <= cpu_ops_q[0].op;
                s_address <= cpu_ops_q[0].addr;
                s_data <= cpu_ops_q[0].data;
                void'(cpu_ops_q.pop_front());
                s_valid <= 1'b1;
                src_gap <= gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- result sink ----------------

    always @(negedge aclk) begin
        if (hold_done != hold_req) begin
            hold_done <= hold_done + 1;
            sink_gap <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            sink_gap <= gap_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------- monitor and watchdog ----------------

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (bank_update_q.size() == 0) begin
                    $error("unexpected transfer: kind %0d slot %0d value %0d last %0d",
                           m_kind, m_slot, m_value, m_last);
                    mismatches++;
                end else begin
                    want = bank_update_q.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("m_kind: expected %0d, actual %0d", want.kind, m_kind);
                        mismatches++;
                    end
                    if (m_slot !== want.slot) begin
                        $error("m_slot: expected %0d, actual %0d", want.slot, m_slot);
                        mismatches++;
                    end
                    if (m_value !== want.value) begin
                        $error("m_value: expected %0d, actual %0d", want.value, m_value);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $error("m_last: expected %0d, actual %0d", want.last, m_last);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_cpu_op(s_opcode, s_address, s_data);
            end
        end
        s_taken <= aresetn && s_valid && s_ready;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
